>>> sv/indexed_sequence_store_core_defines.svh
// Assertion macros shared by the indexed sequence store checker.
// Needs clk and rst_n in scope where a macro is used.
`ifndef INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define ISC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define ISC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ISC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/isc_pkg.sv
// Types and constants of the indexed sequence store.
// No dependencies.
package isc_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CNT_O_W = 7;
  // position width covering the largest supported depth (4096) plus one
  localparam int POS_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_AT     = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        rd_pos;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> sv/isc_channels.sv
// Request and result channel interfaces of the indexed sequence store.
// Depends on isc_pkg.
interface isc_req_if import isc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, index, value, input ready);
  modport sink   (input valid, operation, index, value, output ready);
endinterface

interface isc_rsp_if import isc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [CNT_O_W-1:0]      entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

>>> sv/isc_cell.sv
// One storage cell of the sequence chain: holds one entry, shifts with its neighbours.
// Depends on isc_pkg.
module isc_cell import isc_pkg::*; #(
  parameter int POS = 0
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] left_q,
  input  logic signed [VAL_W-1:0] right_q,
  output logic signed [VAL_W-1:0] data_q,
  output logic signed [VAL_W-1:0] rd_part
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  always_comb begin
    priority if (ctrl.ins && (MY_POS > ctrl.pos)) begin
      data_nxt = left_q;
    end else if (ctrl.ins && (MY_POS == ctrl.pos)) begin
      data_nxt = ctrl.value;
    end else if (ctrl.del && (MY_POS >= ctrl.pos)) begin
      data_nxt = right_q;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q  = data_r;
  assign rd_part = (ctrl.rd_pos == MY_POS) ? data_r : '0;

endmodule

>>> sv/indexed_sequence_store_core.sv
// Indexed sequence store: top level, a chain of DEPTH entry cells plus count and result register.
// Depends on isc_pkg, isc_channels (isc_req_if, isc_rsp_if) and isc_cell.
//
// Holds an ordered list of up to DEPTH signed 32-bit values, head at position 0.
// Each request is read, insert at head, insert at tail, insert before index, or
// delete at index. Every entry sits in its own cell; an insert or delete moves
// all later entries one place along the chain in the same clock, so one request
// can be accepted every cycle unless the result channel stalls. The result is
// registered: it appears on the result channel the cycle after the request is
// taken, and a new request is taken while that result waits as long as it is
// being taken in the same cycle (in ready = result register empty or out ready).
// Reads pick their cell through a per-cell position match ORed onto one bus.
// A read at or past the count returns -1 with status "range"; out-of-range
// inserts and deletes and unknown operation codes change nothing and report
// "range"; an insert into a full store reports "full". The entry count after
// the request comes with every result. No clearing pass after reset: only the
// count and the result valid are reset, and cells at or beyond the count are never read.
module indexed_sequence_store_core import isc_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  isc_req_if.sink      in_req,
  isc_rsp_if.source    out_rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  // list length
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // result register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_read_value_r;
  status_t                 out_status_r;
  logic [CNT_O_W-1:0]      out_entry_count_r;

  logic                    accept;
  op_t                     op;
  logic [POS_W-1:0]        idx_w;
  logic [POS_W-1:0]        cnt_w;
  logic                    full;
  logic [POS_W-1:0]        ins_pos;
  logic                    is_ins;
  logic                    ins_ok;
  logic                    del_ok;
  logic signed [VAL_W-1:0] rsp_value;
  status_t                 rsp_status;
  cell_ctrl_t              ctrl;

  logic signed [VAL_W-1:0] cell_q  [DEPTH];
  logic signed [VAL_W-1:0] rd_part [DEPTH];
  logic signed [VAL_W-1:0] rd_bus;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  assign op    = op_t'(in_req.operation);
  assign idx_w = POS_W'(in_req.index);
  assign cnt_w = POS_W'(count_r);
  assign full  = (cnt_w == POS_W'(DEPTH));

  // operation decode
  always_comb begin
    rsp_value  = '0;
    rsp_status = ST_DONE;
    ins_pos    = idx_w;
    is_ins     = 1'b0;
    del_ok     = 1'b0;
    unique case (op)
      OP_READ: begin
        if (idx_w < cnt_w) begin
          rsp_value = rd_bus;
        end else begin
          rsp_value  = MISS_VALUE;
          rsp_status = ST_RANGE;
        end
      end
      OP_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      OP_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_w;
      end
      OP_AT: begin
        is_ins  = 1'b1;
        ins_pos = idx_w;
      end
      OP_DELETE: begin
        if (idx_w < cnt_w) begin
          del_ok = 1'b1;
        end else begin
          rsp_status = ST_RANGE;
        end
      end
      default: begin
        rsp_status = ST_RANGE;
      end
    endcase

    // range check comes before the full check
    ins_ok = 1'b0;
    if (is_ins) begin
      priority if (ins_pos > cnt_w) begin
        rsp_status = ST_RANGE;
      end else if (full) begin
        rsp_status = ST_FULL;
      end else begin
        ins_ok = 1'b1;
      end
    end
  end

  // broadcast to the chain
  always_comb begin
    ctrl.ins    = accept && ins_ok;
    ctrl.del    = accept && del_ok;
    ctrl.pos    = ins_ok ? ins_pos : idx_w;
    ctrl.rd_pos = idx_w;
    ctrl.value  = in_req.value;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_q;
    logic signed [VAL_W-1:0] right_q;

    // chain ends feed back their own entry: the head never takes it, the
    // tail keeps its stale entry on a delete, which then lies past the count
    if (i == 0) begin : g_head
      assign left_q = cell_q[i];
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    isc_cell #(
      .POS (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (left_q),
      .right_q (right_q),
      .data_q  (cell_q[i]),
      .rd_part (rd_part[i])
    );
  end

  // at most one cell matches the read position
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_part[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r  <= rsp_value;
      out_status_r      <= rsp_status;
      out_entry_count_r <= CNT_O_W'(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = out_read_value_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = out_entry_count_r;

endmodule

>>> sv/isc_checker.sv
// Port-level checks for the indexed sequence store, bound onto the top level.
// Depends on isc_pkg and indexed_sequence_store_core_defines.svh.
`include "indexed_sequence_store_core_defines.svh"

module isc_checker import isc_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic [ST_W-1:0]         out_status,
  input logic [CNT_O_W-1:0]      out_entry_count
);

  `ISC_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid, "result valid after reset")

  `ISC_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_entry_count), "stalled result changed")

  `ISC_ASSERT_IMPLY(a_count_bound, out_valid, 32'(out_entry_count) <= 32'(DEPTH) || DEPTH > 127, "entry count beyond depth")

  `ISC_ASSERT_IMPLY(a_full_count, out_valid && (out_status == ST_FULL), (out_read_value == '0) && (32'(out_entry_count) == (DEPTH % 128)), "full status with wrong count or value")

  `ISC_ASSERT_NEXT(a_accept_shows, in_valid && in_ready, out_valid, "accepted request left no result")

endmodule

bind indexed_sequence_store_core isc_checker #(
  .DEPTH (DEPTH)
) u_isc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_read_value  (out_rsp.read_value),
  .out_status      (out_rsp.status),
  .out_entry_count (out_rsp.entry_count)
);

>>> tb/indexed_sequence_store_core_tb.sv
// Self-checking bench for indexed_sequence_store_core: directed and random requests,
// a list predictor, and random stalls on both channels.
// Depends on isc_pkg, isc_channels and the RTL of the store.
module indexed_sequence_store_core_tb;
  import isc_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int RANDOM_REQS  = 2000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_WAIT     = 17;
  localparam int REPORT_LIMIT = 10;

  // codes 5..7 are not operations; the store must ignore them and flag range
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    int unsigned             gap;    // idle cycles before the request is offered
    bit                      drain;  // hold back until every result is in
  } list_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [CNT_O_W-1:0]      entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  isc_req_if req_ch ();
  isc_rsp_if rsp_ch ();

  indexed_sequence_store_core #(
    .DEPTH (STORE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    #10 clk = ~clk;
  end

  // Stimulus and scoreboard state.
  list_req_t               request_queue[$];   // requests not yet offered
  list_result_t            awaited_results[$]; // predicted results, oldest first
  logic signed [VAL_W-1:0] shadow_list[$];     // predicted list contents, head first
  int                      gen_fill;           // list length as seen by the generator
  int                      request_total;
  int                      accepted_cnt;
  int                      checked_cnt;
  int                      mismatch_cnt;
  int                      full_refusals;
  int                      emptied_by_delete;
  int                      read_misses;

  // --------------------------------------------------------------------------
  // Predictor: applies one request to the shadow list and returns the result
  // the store ought to give. Range is checked before full on an indexed insert.
  // --------------------------------------------------------------------------
  function automatic list_result_t list_outcome(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                logic signed [VAL_W-1:0] val);
    list_result_t r;
    int           len;
    int           pos;
    len          = shadow_list.size();
    pos          = int'(idx);
    r.read_value = '0;
    r.status     = ST_DONE;
    case (op)
      OP_READ: begin
        if (pos < len) begin
          r.read_value = shadow_list[pos];
        end else begin
          r.read_value = MISS_VALUE;
          r.status     = ST_RANGE;
          read_misses++;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        if (op == OP_HEAD) pos = 0;
        if (op == OP_TAIL) pos = len;
        if (pos > len) begin
          r.status = ST_RANGE;
        end else if (len >= STORE_DEPTH) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          shadow_list.insert(pos, val);
        end
      end
      OP_DELETE: begin
        if (pos >= len) begin
          r.status = ST_RANGE;
        end else begin
          shadow_list.delete(pos);
          if (shadow_list.size() == 0) emptied_by_delete++;
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.entry_count = CNT_O_W'(shadow_list.size());
    return r;
  endfunction

  // Queues one request and keeps the generator's view of the length in step,
  // so random indexes can be aimed inside the list.
  task automatic add_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                         logic signed [VAL_W-1:0] val, bit drain);
    list_req_t q;
    q.op    = op;
    q.idx   = idx;
    q.val   = val;
    q.drain = drain;
    // every fifth block of 150 requests is sent back to back
    q.gap   = ((request_queue.size() / 150) % 5 == 4) ? 0 : $urandom_range(0, MAX_WAIT);
    request_queue.push_back(q);
    request_total++;
    case (op)
      OP_HEAD, OP_TAIL: if (gen_fill < STORE_DEPTH) gen_fill++;
      OP_AT:            if (int'(idx) <= gen_fill && gen_fill < STORE_DEPTH) gen_fill++;
      OP_DELETE:        if (int'(idx) < gen_fill) gen_fill--;
      default: ;
    endcase
  endtask

  // Mostly uniform values, with the extremes and small values now and then.
  function automatic logic signed [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return -32'sd1;
      3:       return 32'(signed'($urandom_range(0, 3)));
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers one request at a time; the next is loaded in the same edge
  // as one is taken, so valid drops only for a gap, a drain wait or no request.
  // --------------------------------------------------------------------------
  list_req_t   cur_req;
  bit          holding;
  bit          offer;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= '0;
      req_ch.index     <= '0;
      req_ch.value     <= '0;
      holding = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_results.push_back(list_outcome(cur_req.op, cur_req.idx, cur_req.val));
        accepted_cnt++;
        holding = 1'b0;
      end
      if (!holding && request_queue.size() != 0) begin
        cur_req  = request_queue.pop_front();
        gap_left = cur_req.gap;
        holding  = 1'b1;
      end
      offer = 1'b0;
      if (holding) begin
        // a draining request waits for the store to settle, then its gap
        if (cur_req.drain && awaited_results.size() != 0) begin
          offer = 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          offer = 1'b1;
        end
      end
      req_ch.valid <= offer;
      if (offer) begin
        req_ch.operation <= cur_req.op;
        req_ch.index     <= cur_req.idx;
        req_ch.value     <= cur_req.val;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes results with random back-pressure and checks each against
  // the oldest prediction, field by field.
  // --------------------------------------------------------------------------
  int unsigned  stall_left;
  list_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        checked_cnt++;
        if (awaited_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("result %0d arrived with nothing predicted: rd=%0d st=%0d cnt=%0d",
                     checked_cnt, rsp_ch.read_value, rsp_ch.status, rsp_ch.entry_count);
        end else begin
          want = awaited_results.pop_front();
          if (rsp_ch.read_value !== want.read_value || rsp_ch.status !== want.status ||
              rsp_ch.entry_count !== want.entry_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
              $display("result %0d: want rd=%0d st=%0d cnt=%0d, got rd=%0d st=%0d cnt=%0d",
                       checked_cnt, want.read_value, want.status, want.entry_count,
                       rsp_ch.read_value, rsp_ch.status, rsp_ch.entry_count);
          end
        end
        // every fourth block of 170 results is taken without stalls
        stall_left = ((checked_cnt / 170) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int               k;
    int               pick;
    int               linger;
    bit               filling;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;

    rst_n = 1'b0;

    // Directed: empty-store corner cases first.
    add_req(OP_READ,   7'd0,  32'sd5, 1'b0);  // read on empty misses
    add_req(OP_DELETE, 7'd0,  32'sd0, 1'b0);  // delete on empty is ignored
    add_req(OP_DELETE, 7'd64, 32'sd0, 1'b0);
    add_req(OP_AT,     7'd1,  32'sd9, 1'b0);  // insert past the end is ignored
    add_req(OP_AT,     7'd0,  32'sd9, 1'b0);  // indexed insert at 0 on empty
    add_req(OP_DELETE, 7'd0,  32'sd0, 1'b0);  // deleting the only entry empties it
    add_req(OP_READ,   7'd0,  32'sd0, 1'b0);  // no stale tail left behind
    // Build a short list with the value extremes.
    add_req(OP_HEAD,   7'd0,  VAL_MAX, 1'b0);
    add_req(OP_TAIL,   7'd0,  VAL_MIN, 1'b0);
    add_req(OP_AT,     7'd1,  -32'sd1, 1'b0);
    add_req(OP_AT,     7'd3,  32'sd0,  1'b0); // index equal to length appends
    add_req(OP_AT,     7'd5,  32'sd7,  1'b0); // index beyond length ignored
    add_req(OP_READ,   7'd0,  32'sd0,  1'b0);
    add_req(OP_READ,   7'd1,  32'sd0,  1'b0);
    add_req(OP_READ,   7'd2,  32'sd0,  1'b0);
    add_req(OP_READ,   7'd3,  32'sd0,  1'b0);
    add_req(OP_READ,   7'd4,  32'sd0,  1'b0); // just past the end
    add_req(OP_READ,   7'd64, 32'sd0,  1'b0);
    add_req(OP_DELETE, 7'd1,  32'sd0,  1'b0);
    add_req(OP_DELETE, 7'd3,  32'sd0,  1'b0); // equal to length: ignored
    add_req(OP_DELETE, 7'd2,  32'sd0,  1'b0); // tail entry
    add_req(OP_UNDEF_LO, 7'd64, VAL_MAX, 1'b0);
    add_req(OP_UNDEF_HI, 7'd0,  VAL_MIN, 1'b0);
    add_req(OP_READ,   7'd1,  32'sd0,  1'b1); // sent only once the store is idle

    // Random: alternate fill and drain phases so the full store and the empty
    // store are both reached many times; indexes mostly land inside the list.
    filling = 1'b1;
    linger  = 0;
    for (k = 0; k < RANDOM_REQS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick == 99) begin
        op = OP_W'($urandom_range(5, 7));
      end else if (pick < 20) begin
        op = OP_READ;
      end else if ((filling && pick < 80) || (!filling && pick < 35)) begin
        case ($urandom_range(0, 2))
          0:       op = OP_HEAD;
          1:       op = OP_TAIL;
          default: op = OP_AT;
        endcase
      end else begin
        op = OP_DELETE;
      end
      if ($urandom_range(0, 6) == 0)
        idx = IDX_W'($urandom_range(0, STORE_DEPTH));
      else if (op == OP_AT)
        idx = IDX_W'($urandom_range(0, gen_fill));
      else
        idx = (gen_fill == 0) ? '0 : IDX_W'($urandom_range(0, gen_fill - 1));
      add_req(op, idx, draw_value(), $urandom_range(0, 99) == 0);
      if (filling && gen_fill == STORE_DEPTH) begin
        // stay at full for a while to hammer the refusal path
        linger++;
        if (linger > 12) begin
          filling = 1'b0;
          linger  = 0;
        end
      end else if (!filling && gen_fill == 0) begin
        linger++;
        if (linger > 4) begin
          filling = 1'b1;
          linger  = 0;
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted_cnt == request_total && awaited_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d read misses", request_total,
             checked_cnt, read_misses);
    $display("%0d inserts refused on a full store, list emptied by delete %0d times",
             full_refusals, emptied_by_delete);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin
    #(10_000_000);
    $display("timeout: %0d of %0d requests taken, %0d results outstanding", accepted_cnt,
             request_total, awaited_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
